@@ rtl/gpenc_pkg.sv @@
// Shared package for the gamepad encoder and key debouncer.
// Holds register reset values, configuration register indexes and the turn direction type.
// No dependencies.
`default_nettype none
package gpenc_pkg;

	localparam int KEYS_DEF = 16;
	localparam int KEY_OUT_W = 16;
	localparam int MASK_W = 8;
	localparam int IDX_W = 4;

	localparam logic [MASK_W-1:0] MASK_RST = 8'h01;
	localparam logic [IDX_W-1:0] RIGHT_RST = 4'd7;
	localparam logic [IDX_W-1:0] LEFT_RST = 4'd6;

	typedef enum logic [1:0] {
		CFG_HISTORY_MASK = 2'd0,
		CFG_RIGHT_KEY = 2'd1,
		CFG_LEFT_KEY = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} turn_t;

endpackage
`default_nettype wire

@@ rtl/gpenc_encoder.sv @@
// Quadrature encoder turn accumulator with 16-bit signed saturation.
// Depends on gpenc_pkg for the turn direction type.
`default_nettype none
module gpenc_encoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ev_en,
	input  wire logic          enc_a,
	input  wire logic          enc_b,
	input  wire logic          tick_clr,
	output gpenc_pkg::turn_t   turn
);
	import gpenc_pkg::*;

	localparam logic signed [15:0] ACC_MAX = 16'sh7FFF;
	localparam logic signed [15:0] ACC_MIN = -16'sh8000;

	logic prev_a_q;
	logic prev_b_q;
	logic signed [15:0] accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b0;
			prev_b_q <= 1'b0;
			accum_q <= '0;
		end else if (tick_clr) begin
			accum_q <= '0;
		end else if (ev_en && (enc_a != prev_a_q)) begin
			prev_a_q <= enc_a;
			if (enc_b != prev_b_q) begin
				prev_b_q <= enc_b;
				if (enc_a == enc_b) begin
					if (accum_q != ACC_MAX) begin
						accum_q <= accum_q + 16'sd1;
					end
				end else begin
					if (accum_q != ACC_MIN) begin
						accum_q <= accum_q - 16'sd1;
					end
				end
			end
		end
	end

	assign turn.neg = accum_q[15];
	assign turn.pos = !accum_q[15] && (accum_q != '0);

endmodule
`default_nettype wire

@@ rtl/gpenc_debounce.sv @@
// Per-key shift history debouncer; all keys update in parallel on a poll tick.
// Depends on gpenc_pkg for the mask width.
`default_nettype none
module gpenc_debounce #(
	parameter int KEYS = gpenc_pkg::KEYS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tick_en,
	input  wire logic [KEYS-1:0]               key_bits,
	input  wire logic [gpenc_pkg::MASK_W-1:0]  history_mask,
	output logic [KEYS-1:0]                    held_next
);
	import gpenc_pkg::*;

	logic [MASK_W-1:0] hist_q [KEYS];
	logic [MASK_W-1:0] hist_nxt [KEYS];
	logic [KEYS-1:0] held_q;
	logic [KEYS-1:0] held_nxt;

	always_comb begin
		held_nxt = held_q;
		for (int i = 0; i < KEYS; i++) begin
			hist_nxt[i] = {hist_q[i][MASK_W-2:0], key_bits[i]} & history_mask;
			if (hist_nxt[i] == history_mask) begin
				held_nxt[i] = 1'b1;
			end else if (hist_nxt[i] == '0) begin
				held_nxt[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < KEYS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (tick_en) begin
			held_q <= held_nxt;
			for (int i = 0; i < KEYS; i++) begin
				hist_q[i] <= hist_nxt[i];
			end
		end
	end

	assign held_next = held_nxt;

endmodule
`default_nettype wire

@@ rtl/gamepad_encoder_debounce.sv @@
// Top level: input register, encoder accumulator, key debouncer and result register.
// Depends on gpenc_pkg, gpenc_encoder and gpenc_debounce.
// A poll tick passes the input register, then the result register, which holds its key word.
// One item is accepted every cycle unless a poll tick waits on a stalled result register.
// Encoder events give no result. Reset clears all but data registers and loads defaults.
`default_nettype none
module gamepad_encoder_debounce #(
	parameter int KEYS = gpenc_pkg::KEYS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              mode,
	input  wire logic                              enc_a,
	input  wire logic                              enc_b,
	input  wire logic [gpenc_pkg::KEY_OUT_W-1:0]   raw_keys,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [gpenc_pkg::KEY_OUT_W-1:0]        key_state,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [gpenc_pkg::MASK_W-1:0]      cfg_data
);
	import gpenc_pkg::*;

	localparam int EXT_W = (KEYS > KEY_OUT_W) ? KEYS : KEY_OUT_W;

	logic [MASK_W-1:0] mask_q;
	logic [IDX_W-1:0] right_q;
	logic [IDX_W-1:0] left_q;

	logic valid_s1;
	logic mode_s1;
	logic enc_a_s1;
	logic enc_b_s1;
	logic [KEY_OUT_W-1:0] raw_s1;

	logic out_valid_q;
	logic [KEY_OUT_W-1:0] key_state_q;

	logic advance;
	logic ev_en;
	logic tick_en;
	turn_t turn;
	logic [EXT_W-1:0] raw_ext;
	logic [KEYS-1:0] key_bits;
	logic [KEYS-1:0] held_next;
	logic [EXT_W-1:0] held_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RST;
			right_q <= RIGHT_RST;
			left_q <= LEFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HISTORY_MASK: mask_q <= cfg_data;
				CFG_RIGHT_KEY: right_q <= cfg_data[IDX_W-1:0];
				CFG_LEFT_KEY: left_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// A poll tick needs a free result register; an encoder event always moves on.
	assign advance = valid_s1 && (!mode_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign ev_en = advance && !mode_s1;
	assign tick_en = advance && mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			enc_a_s1 <= enc_a;
			enc_b_s1 <= enc_b;
			raw_s1 <= raw_keys;
		end
	end

	gpenc_encoder u_encoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_en    (ev_en),
		.enc_a    (enc_a_s1),
		.enc_b    (enc_b_s1),
		.tick_clr (tick_en),
		.turn     (turn)
	);

	always_comb begin
		raw_ext = EXT_W'(raw_s1);
		for (int i = 0; i < KEYS; i++) begin
			key_bits[i] = raw_ext[i]
				| (turn.neg && (32'(right_q) == i))
				| (turn.pos && (32'(left_q) == i));
		end
	end

	gpenc_debounce #(
		.KEYS (KEYS)
	) u_debounce (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_en      (tick_en),
		.key_bits     (key_bits),
		.history_mask (mask_q),
		.held_next    (held_next)
	);

	// The debouncer updates on the same edge; the result register takes its next value.
	assign held_ext = EXT_W'(held_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			key_state_q <= held_ext[KEY_OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign key_state = key_state_q;

endmodule
`default_nettype wire
